// ----- rtl/sdvs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sdvs_pkg;

  // Field and state widths
  localparam int VAL_W     = 8;
  localparam int TIME_W    = 32;
  localparam int FIX_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 2'd3;

  // Configuration reset values
  localparam logic [CFG_W-1:0] DAMPING_RST = 16'd256;
  localparam logic [CFG_W-1:0] FREQ_RST    = 16'd2560;
  localparam logic [VAL_W-1:0] MAX_RST     = 8'd255;
  localparam logic [CFG_W-1:0] SETTLE_RST  = 16'd500;

  // Datapath widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = 60;
  localparam int K1_W   = 25;
  localparam int K2_W   = 24;
  localparam int DIV_W  = 64;
  localparam int QUO_W  = 54;
  localparam int DQ_W   = QUO_W + 1;
  localparam int WHOLE_W = 17;

  // Divide-by-1000 unit: long division in 16-bit digits. Each digit
  // quotient comes from a reciprocal multiply; the reciprocal is
  // ceil(2^36 / 1000), exact for every partial dividend below 2^26.
  localparam int DIVISOR   = 1000;
  localparam int DIV_HALF  = DIVISOR / 2;
  localparam int DIV_REM_W = $clog2(DIVISOR);
  localparam int DIG_W     = 16;
  localparam int N_DIG     = DIV_W / DIG_W;
  localparam int DIG_CNT_W = $clog2(N_DIG);
  localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(N_DIG - 1);
  localparam int PART_W    = DIV_REM_W + DIG_W;
  localparam int RECIP_SH  = PART_W + DIV_REM_W;
  localparam int RECIP_W   = RECIP_SH - DIV_REM_W + 1;
  localparam int SCALED_W  = PART_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  // Microcode layout
  localparam int OP_W   = 5;
  localparam int COND_W = 3;
  localparam int PC_W   = 5;

  // Datapath operations
  localparam logic [OP_W-1:0] OP_NOP        = 5'd0;
  localparam logic [OP_W-1:0] OP_MUL_ZW     = 5'd1;
  localparam logic [OP_W-1:0] OP_MUL_WW     = 5'd2;
  localparam logic [OP_W-1:0] OP_MUL_K1V    = 5'd3;
  localparam logic [OP_W-1:0] OP_MUL_K2E    = 5'd4;
  localparam logic [OP_W-1:0] OP_SUM_SUB    = 5'd5;
  localparam logic [OP_W-1:0] OP_ACC        = 5'd6;
  localparam logic [OP_W-1:0] OP_MUL_ADT    = 5'd7;
  localparam logic [OP_W-1:0] OP_MUL_VDT    = 5'd8;
  localparam logic [OP_W-1:0] OP_DIV_START  = 5'd9;
  localparam logic [OP_W-1:0] OP_DQ_LOAD    = 5'd10;
  localparam logic [OP_W-1:0] OP_VEL_ADD    = 5'd11;
  localparam logic [OP_W-1:0] OP_POS_ADD    = 5'd12;
  localparam logic [OP_W-1:0] OP_CHK_CHG    = 5'd13;
  localparam logic [OP_W-1:0] OP_CHK_SETTLE = 5'd14;
  localparam logic [OP_W-1:0] OP_SHOW       = 5'd15;
  localparam logic [OP_W-1:0] OP_EMIT       = 5'd16;
  localparam logic [OP_W-1:0] OP_SET_TGT    = 5'd17;

  // Jump conditions
  localparam logic [COND_W-1:0] C_NEVER      = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS     = 3'd1;
  localparam logic [COND_W-1:0] C_NO_ITEM    = 3'd2;
  localparam logic [COND_W-1:0] C_IS_TARGET  = 3'd3;
  localparam logic [COND_W-1:0] C_NOT_MOVING = 3'd4;
  localparam logic [COND_W-1:0] C_DT_LE1     = 3'd5;
  localparam logic [COND_W-1:0] C_DIV_BUSY   = 3'd6;
  localparam logic [COND_W-1:0] C_OUT_BUSY   = 3'd7;

  // One control word of the program
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } uword_t;

  // Flags the datapath reports to the sequencer
  typedef struct packed {
    logic is_target;
    logic moving;
    logic dt_le1;
    logic out_busy;
  } dp_status_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [FIX_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [FIX_W-1:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[FIX_W-1:0];
    end
    return r;
  endfunction

  // Q16.16 position to integer, rounded half away from zero.
  function automatic logic signed [WHOLE_W-1:0] round_whole(input logic signed [FIX_W-1:0] p);
    logic [FIX_W:0] t;
    t = {p[FIX_W-1], p} + (p[FIX_W-1] ? 33'd32767 : 33'd32768);
    return t[FIX_W:16];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sdvs_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one command item per handshake.
interface sdvs_in_if;
  import sdvs_pkg::*;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [TIME_W-1:0]   now_ms;
  logic [VAL_W-1:0]    target_value;
  modport source (output valid, cmd, now_ms, target_value, input ready);
  modport sink   (input valid, cmd, now_ms, target_value, output ready);
endinterface

// Output channel: one result item per handshake.
interface sdvs_out_if;
  import sdvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic             active;
  modport source (output valid, value, active, input ready);
  modport sink   (input valid, value, active, output ready);
endinterface

`default_nettype wire

// ----- rtl/sdvs_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdvs_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     div_busy,
  input  sdvs_pkg::dp_status_t     st,
  output logic [sdvs_pkg::OP_W-1:0] op,
  output logic                     idle
);
  import sdvs_pkg::*;

  // Jump targets in the program
  localparam logic [PC_W-1:0] L_IDLE    = 5'd0;
  localparam logic [PC_W-1:0] L_WAIT_V  = 5'd12;
  localparam logic [PC_W-1:0] L_WAIT_P  = 5'd17;
  localparam logic [PC_W-1:0] L_SHOW    = 5'd22;
  localparam logic [PC_W-1:0] L_EMIT    = 5'd23;
  localparam logic [PC_W-1:0] L_SET_TGT = 5'd25;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          uw;
  logic            take;

  // Program store: one control word per step.
  function automatic uword_t rom(input logic [PC_W-1:0] a);
    uword_t w;
    unique case (a)
      5'd0:    w = '{OP_NOP,        C_NO_ITEM,    L_IDLE};
      5'd1:    w = '{OP_NOP,        C_IS_TARGET,  L_SET_TGT};
      5'd2:    w = '{OP_NOP,        C_NOT_MOVING, L_EMIT};
      5'd3:    w = '{OP_NOP,        C_DT_LE1,     L_SHOW};
      5'd4:    w = '{OP_MUL_ZW,     C_NEVER,      L_IDLE};
      5'd5:    w = '{OP_MUL_WW,     C_NEVER,      L_IDLE};
      5'd6:    w = '{OP_MUL_K1V,    C_NEVER,      L_IDLE};
      5'd7:    w = '{OP_MUL_K2E,    C_NEVER,      L_IDLE};
      5'd8:    w = '{OP_SUM_SUB,    C_NEVER,      L_IDLE};
      5'd9:    w = '{OP_ACC,        C_NEVER,      L_IDLE};
      5'd10:   w = '{OP_MUL_ADT,    C_NEVER,      L_IDLE};
      5'd11:   w = '{OP_DIV_START,  C_NEVER,      L_IDLE};
      5'd12:   w = '{OP_NOP,        C_DIV_BUSY,   L_WAIT_V};
      5'd13:   w = '{OP_DQ_LOAD,    C_NEVER,      L_IDLE};
      5'd14:   w = '{OP_VEL_ADD,    C_NEVER,      L_IDLE};
      5'd15:   w = '{OP_MUL_VDT,    C_NEVER,      L_IDLE};
      5'd16:   w = '{OP_DIV_START,  C_NEVER,      L_IDLE};
      5'd17:   w = '{OP_NOP,        C_DIV_BUSY,   L_WAIT_P};
      5'd18:   w = '{OP_DQ_LOAD,    C_NEVER,      L_IDLE};
      5'd19:   w = '{OP_POS_ADD,    C_NEVER,      L_IDLE};
      5'd20:   w = '{OP_CHK_CHG,    C_NEVER,      L_IDLE};
      5'd21:   w = '{OP_CHK_SETTLE, C_NEVER,      L_IDLE};
      5'd22:   w = '{OP_SHOW,       C_NEVER,      L_IDLE};
      5'd23:   w = '{OP_EMIT,       C_OUT_BUSY,   L_EMIT};
      5'd24:   w = '{OP_NOP,        C_ALWAYS,     L_IDLE};
      5'd25:   w = '{OP_SET_TGT,    C_ALWAYS,     L_EMIT};
      default: w = '{OP_NOP,        C_ALWAYS,     L_IDLE};
    endcase
    return w;
  endfunction

  assign uw   = rom(pc);
  assign op   = uw.op;
  assign idle = (pc == L_IDLE);

  // Select the jump condition of the current step.
  always_comb begin
    unique case (uw.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_ITEM:    take = !in_valid;
      C_IS_TARGET:  take = st.is_target;
      C_NOT_MOVING: take = !st.moving;
      C_DT_LE1:     take = st.dt_le1;
      C_DIV_BUSY:   take = div_busy;
      C_OUT_BUSY:   take = st.out_busy;
      default:      take = 1'b0;
    endcase
    pc_next = take ? uw.target : pc + PC_W'(1);
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= L_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sdvs_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdvs_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [sdvs_pkg::DIV_W-1:0]     dividend,
  output logic                           busy,
  output logic [sdvs_pkg::QUO_W-1:0]     quotient
);
  import sdvs_pkg::*;

  logic [DIV_W-1:0]     num;
  logic [DIV_REM_W-1:0] rem;
  logic [DIG_CNT_W-1:0] cnt;
  logic                 phase;
  logic [DIG_W-1:0]     qd;
  logic [PART_W-1:0]    part;
  logic [SCALED_W-1:0]  scaled;
  logic [PART_W-1:0]    back;

  // Partial dividend: the remainder so far followed by the next digit.
  assign part   = {rem, num[DIV_W-1 -: DIG_W]};
  assign scaled = {{RECIP_W{1'b0}}, part} * {{PART_W{1'b0}}, RECIP};
  assign back   = part - PART_W'(qd) * PART_W'(DIVISOR);

  assign quotient = num[QUO_W-1:0];

  // Control: for each digit, the digit quotient first, then the remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      phase <= 1'b0;
      cnt   <= '0;
    end else if (busy) begin
      phase <= !phase;
      if (phase) begin
        cnt <= cnt + DIG_CNT_W'(1);
        if (cnt == DIG_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Digit quotient, partial remainder and dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (!phase) begin
        qd <= scaled[RECIP_SH +: DIG_W];
      end else begin
        num <= {num[DIV_W-DIG_W-1:0], qd};
        rem <= back[DIV_REM_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sdvs_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdvs_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [sdvs_pkg::OP_W-1:0]       op,
  input  logic                            in_fire,
  input  logic                            in_cmd,
  input  logic [sdvs_pkg::TIME_W-1:0]     in_now,
  input  logic [sdvs_pkg::VAL_W-1:0]      in_tv,
  input  logic                            cfg_we,
  input  logic [sdvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdvs_pkg::CFG_W-1:0]      cfg_data,
  input  logic [sdvs_pkg::QUO_W-1:0]      quotient,
  output logic                            div_start,
  output logic [sdvs_pkg::DIV_W-1:0]      div_dividend,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [sdvs_pkg::VAL_W-1:0]      out_value,
  output logic                            out_active,
  output sdvs_pkg::dp_status_t            st
);
  import sdvs_pkg::*;

  // Configuration
  logic [CFG_W-1:0] damping_ratio;
  logic [CFG_W-1:0] natural_freq;
  logic [VAL_W-1:0] max_value;
  logic [CFG_W-1:0] settle_ms;

  // Latched input item
  logic              cmd_r;
  logic [TIME_W-1:0] now_r;
  logic [VAL_W-1:0]  tv_r;

  // Smoother state
  logic signed [FIX_W-1:0] position;
  logic signed [FIX_W-1:0] velocity;
  logic [VAL_W-1:0]        target;
  logic [TIME_W-1:0]       last_update_ms;
  logic [TIME_W-1:0]       last_change_ms;
  logic                    moving;
  logic [VAL_W-1:0]        shown_value;

  // Working registers
  logic signed [PROD_W-1:0] prod;
  logic [K1_W-1:0]          k1;
  logic [K2_W-1:0]          k2;
  logic [SUM_W-1:0]         sum;
  logic signed [FIX_W-1:0]  acc;
  logic [TIME_W-1:0]        dt;
  logic                     neg;
  logic [DQ_W-1:0]          dq;

  // Combinational helpers
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic                      mul_en;
  logic signed [MUL_W-1:0]   err;
  logic [SUM_W-1:0]          rnd;
  logic [TIME_W-1:0]         dt_now;
  logic [TIME_W-1:0]         since_chg;
  logic signed [WHOLE_W-1:0] whole;
  logic [DQ_W-1:0]           qx;
  logic                      out_busy;
  logic                      tgt_restart;

  assign err       = $signed({position[FIX_W-1], position}) - $signed({9'b0, target, 16'b0});
  assign rnd       = sum + (sum[SUM_W-1] ? SUM_W'(127) : SUM_W'(128));
  assign dt_now    = now_r - last_update_ms;
  assign since_chg = now_r - last_change_ms;
  assign whole     = round_whole(position);
  assign qx        = {1'b0, quotient};
  assign out_busy  = out_valid && !out_ready;
  assign tgt_restart = (tv_r != target) && (since_chg >= {16'b0, settle_ms});

  assign st.is_target = cmd_r;
  assign st.moving    = moving;
  assign st.dt_le1    = (dt_now <= 32'd1);
  assign st.out_busy  = out_busy;

  // Shared multiplier operand selection
  always_comb begin
    mul_en = 1'b1;
    case (op)
      OP_MUL_ZW: begin
        mul_a = $signed({17'b0, damping_ratio});
        mul_b = $signed({17'b0, natural_freq});
      end
      OP_MUL_WW: begin
        mul_a = $signed({17'b0, natural_freq});
        mul_b = $signed({17'b0, natural_freq});
      end
      OP_MUL_K1V: begin
        mul_a = $signed({velocity[FIX_W-1], velocity});
        mul_b = $signed({8'b0, k1});
      end
      OP_MUL_K2E: begin
        mul_a = err;
        mul_b = $signed({9'b0, k2});
      end
      OP_MUL_ADT: begin
        mul_a = $signed({acc[FIX_W-1], acc});
        mul_b = $signed({1'b0, dt});
      end
      OP_MUL_VDT: begin
        mul_a = $signed({velocity[FIX_W-1], velocity});
        mul_b = $signed({1'b0, dt});
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Magnitude plus half the divisor goes to the divide unit.
  assign div_start    = (op == OP_DIV_START);
  assign div_dividend = prod[DIV_W-1] ? (~prod[DIV_W-1:0] + DIV_W'(DIV_HALF + 1))
                                      : (prod[DIV_W-1:0] + DIV_W'(DIV_HALF));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      damping_ratio <= DAMPING_RST;
      natural_freq  <= FREQ_RST;
      max_value     <= MAX_RST;
      settle_ms     <= SETTLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DAMPING: damping_ratio <= cfg_data;
        CFG_FREQ:    natural_freq  <= cfg_data;
        CFG_MAX:     max_value     <= cfg_data[VAL_W-1:0];
        CFG_SETTLE:  settle_ms     <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Input item latch
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_cmd;
      now_r <= in_now;
      tv_r  <= in_tv;
    end
  end

  // Arithmetic working registers
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_p;
    end
    case (op)
      OP_MUL_ZW:  dt  <= dt_now;
      OP_MUL_WW:  k1  <= prod[31:7];
      OP_MUL_K1V: k2  <= prod[31:8];
      OP_MUL_K2E: sum <= SUM_W'(0) - prod[SUM_W-1:0];
      OP_SUM_SUB: sum <= sum - prod[SUM_W-1:0];
      OP_ACC:     acc <= sat32({{12{rnd[SUM_W-1]}}, rnd[SUM_W-1:8]});
      OP_DIV_START: neg <= prod[DIV_W-1];
      OP_DQ_LOAD: dq  <= neg ? DQ_W'(0) - qx : qx;
      default:    ;
    endcase
  end

  // Smoother state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      velocity       <= '0;
      target         <= '0;
      last_update_ms <= '0;
      last_change_ms <= '0;
      moving         <= 1'b0;
      shown_value    <= '0;
    end else begin
      case (op)
        OP_MUL_ZW: last_update_ms <= now_r;
        OP_VEL_ADD: begin
          velocity <= sat32({{32{velocity[FIX_W-1]}}, velocity} + {{9{dq[DQ_W-1]}}, dq});
        end
        OP_POS_ADD: begin
          position <= sat32({{32{position[FIX_W-1]}}, position} + {{9{dq[DQ_W-1]}}, dq});
        end
        OP_CHK_CHG: begin
          if (whole != {9'b0, target}) begin
            last_change_ms <= now_r;
          end
        end
        OP_CHK_SETTLE: begin
          if (since_chg > {16'b0, settle_ms}) begin
            moving <= 1'b0;
          end
        end
        OP_SHOW: begin
          if (whole[WHOLE_W-1]) begin
            shown_value <= '0;
          end else if (whole[15:0] > {8'b0, max_value}) begin
            shown_value <= max_value;
          end else begin
            shown_value <= whole[VAL_W-1:0];
          end
        end
        OP_SET_TGT: begin
          if (tgt_restart) begin
            last_update_ms <= now_r;
            last_change_ms <= now_r;
            moving         <= 1'b1;
          end
          target <= tv_r;
        end
        default: ;
      endcase
    end
  end

  // Output register: holds one result item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT && !out_busy) begin
      out_value  <= shown_value;
      out_active <= moving;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/spring_damper_value_smoother.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                          Handshake
// in_ch     in   cmd, now_ms[31:0], target_value  valid/ready
// out_ch    out  value[7:0], active               valid/ready
// cfg       in   cfg_index[1:0], cfg_data[15:0]   cfg_we, no wait
//
// A set-target item or a tick while settled goes straight to the output step;
// a tick 1 ms or less after the last step updates the shown value first.
// A tick that runs an Euler step also runs the two divides by 1000 in the
// divide unit, which works through the dividend one 16-bit digit at a time.
// Synchronous reset clears the program counter and state and restores the
// configuration defaults. A result waits in the output register; the next item
// is taken meanwhile, and the program holds at its output step while it is full.

module spring_damper_value_smoother (
  input  logic                            clk,
  input  logic                            rst,
  sdvs_in_if.sink                         in_ch,
  sdvs_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [sdvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdvs_pkg::CFG_W-1:0]      cfg_data
);
  import sdvs_pkg::*;

  logic [OP_W-1:0]  op;
  logic             idle;
  logic             in_fire;
  dp_status_t       st;
  logic             div_start;
  logic             div_busy;
  logic [DIV_W-1:0] div_dividend;
  logic [QUO_W-1:0] quotient;
  logic             out_valid;
  logic [VAL_W-1:0] out_value;
  logic             out_active;

  assign in_ch.ready = idle;
  assign in_fire     = in_ch.valid && idle;

  assign out_ch.valid  = out_valid;
  assign out_ch.value  = out_value;
  assign out_ch.active = out_active;

  // Program sequencer
  sdvs_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .div_busy (div_busy),
    .st       (st),
    .op       (op),
    .idle     (idle)
  );

  // Datapath
  sdvs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .in_fire      (in_fire),
    .in_cmd       (in_ch.cmd),
    .in_now       (in_ch.now_ms),
    .in_tv        (in_ch.target_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .quotient     (quotient),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .out_ready    (out_ch.ready),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .out_active   (out_active),
    .st           (st)
  );

  // Divide-by-1000 unit
  sdvs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .busy     (div_busy),
    .quotient (quotient)
  );

endmodule

`default_nettype wire

// ----- rtl/sdvs_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdvs_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_value,
  input logic       out_active
);

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // The program leaves its idle step as soon as an item is taken.
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after an item was taken");

  // A new result only appears while an item is still being finished.
  a_result_not_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready)
    else $error("result appeared while the block was idle");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_active))
    else $error("stalled result changed");

endmodule

bind spring_damper_value_smoother sdvs_chk u_sdvs_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.value),
  .out_active (out_ch.active)
);

`default_nettype wire
